>>> src/cfd_pkg.sv
// Package for the CAN receive filter / field demux block.
// Holds sizes, command and kind codes, item structs and the width helper.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cfd_pkg;

  // Table sizes
  localparam int FILTER_SLOTS    = 16;
  localparam int MAPS_PER_FILTER = 16;
  localparam int FSLOT_W         = $clog2(FILTER_SLOTS);
  localparam int MSLOT_W         = $clog2(MAPS_PER_FILTER);
  localparam int MAP_ADDR_W      = FSLOT_W + MSLOT_W;
  localparam int FCNT_W          = $clog2(FILTER_SLOTS + 1);
  localparam int MCNT_W          = $clog2(MAPS_PER_FILTER + 1);

  // Command codes
  localparam logic [1:0] CMD_FILTER = 2'd0;
  localparam logic [1:0] CMD_MAP    = 2'd1;
  localparam logic [1:0] CMD_RECV   = 2'd2;

  // Mapping kind codes
  localparam logic [2:0] KIND_BIT   = 3'd0;
  localparam logic [2:0] KIND_BYTE  = 3'd1;
  localparam logic [2:0] KIND_WORD  = 3'd2;
  localparam logic [2:0] KIND_DWORD = 3'd3;
  localparam logic [2:0] KIND_LWORD = 3'd4;

  // Input item
  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  frame_slot;
    logic [3:0]  map_slot;
    logic [28:0] can_id;
    logic        extended;
    logic [4:0]  length;
    logic [63:0] payload;
    logic [2:0]  data_kind;
    logic [2:0]  start_byte;
    logic [2:0]  bit_index;
    logic [3:0]  target_area;
    logic [9:0]  target_index;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [3:0]  area;
    logic [9:0]  index;
    logic [2:0]  bit_res;
    logic [2:0]  kind;
    logic [63:0] value;
    logic        last;
  } out_item_t;

  // Stored filter entry
  typedef struct packed {
    logic [28:0]       ident;
    logic              ext;
    logic [MCNT_W-1:0] count;
  } filter_entry_t;

  // Stored mapping entry
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] offset;
    logic [2:0] bit_sel;
    logic [3:0] area;
    logic [9:0] index;
  } map_entry_t;

  // Write request into the tables
  typedef struct packed {
    logic                  filt_we;
    logic                  map_we;
    logic [FSLOT_W-1:0]    fslot;
    logic [MAP_ADDR_W-1:0] maddr;
    filter_entry_t         filt;
    map_entry_t            map;
  } tbl_wr_t;

  // Field width in bytes for a kind; 0 for an unknown kind
  function automatic logic [3:0] kind_width(input logic [2:0] kind);
    logic [3:0] w;
    case (kind)
      KIND_BIT:   w = 4'd1;
      KIND_BYTE:  w = 4'd1;
      KIND_WORD:  w = 4'd2;
      KIND_DWORD: w = 4'd4;
      KIND_LWORD: w = 4'd8;
      default:    w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> src/cfd_table_store.sv
// Filter table and mapping table, synchronous RAMs with registered read.
// Written from load commands, read by the run sequencer. Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_table_store (
  input  wire logic                          clk,
  input  wire cfd_pkg::tbl_wr_t              wr,
  input  wire logic [cfd_pkg::FSLOT_W-1:0]   filt_raddr,
  output cfd_pkg::filter_entry_t             filt_rdata,
  input  wire logic [cfd_pkg::MAP_ADDR_W-1:0] map_raddr,
  output cfd_pkg::map_entry_t                map_rdata
);
  import cfd_pkg::*;

  filter_entry_t filt_mem [FILTER_SLOTS];
  map_entry_t    map_mem  [FILTER_SLOTS * MAPS_PER_FILTER];

  // Filter RAM: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr.filt_we) begin
      filt_mem[wr.fslot] <= wr.filt;
    end
    filt_rdata <= filt_mem[filt_raddr];
  end

  // Mapping RAM: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr.map_we) begin
      map_mem[wr.maddr] <= wr.map;
    end
    map_rdata <= map_mem[map_raddr];
  end

endmodule

`default_nettype wire

>>> src/cfd_extract.sv
// Field extractor: checks a mapping against the frame length and pulls
// the bit or little-endian byte field out of the payload. Depends on cfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfd_extract (
  input  wire cfd_pkg::map_entry_t map,
  input  wire logic [63:0]         payload,
  input  wire logic [3:0]          dlc,
  output logic                     hit,
  output cfd_pkg::out_item_t       item
);
  import cfd_pkg::*;

  logic [3:0]  width;
  logic [4:0]  field_end;
  logic [63:0] shifted;
  logic [63:0] value;

  // Fit check: field must end within the frame
  assign width     = kind_width(map.kind);
  assign field_end = {2'b00, map.offset} + {1'b0, width};
  assign hit       = (width != 4'd0) && (field_end <= {1'b0, dlc});

  // Align the first field byte to bit 0
  assign shifted = payload >> {map.offset, 3'b000};

  // Mask to the field width
  always_comb begin
    case (map.kind)
      KIND_BIT:   value = {63'd0, shifted[map.bit_sel]};
      KIND_BYTE:  value = {56'd0, shifted[7:0]};
      KIND_WORD:  value = {48'd0, shifted[15:0]};
      KIND_DWORD: value = {32'd0, shifted[31:0]};
      KIND_LWORD: value = shifted;
      default:    value = 64'd0;
    endcase
  end

  always_comb begin
    item.area    = map.area;
    item.index   = map.index;
    item.bit_res = (map.kind == KIND_BIT) ? map.bit_sel : 3'd0;
    item.kind    = map.kind;
    item.value   = value;
    item.last    = 1'b0;
  end

endmodule

`default_nettype wire

>>> src/can_rx_frame_field_demux_core.sv
// CAN receive filter and field demux, top level.
// Load commands never raise busy. A receive item walks the active filters, a RAM
// read and a compare per slot, up to the first match, then that filter's mappings,
// a RAM read and a check each, then a closing step; no new item is taken until then.
// Results come out one per strobe, the last one marked in the same cycle busy falls.
// Results cannot be stalled by the receiver.
// Reset clears control state and active_filters; table contents are not reset.
`timescale 1ns / 1ps
`default_nettype none

module can_rx_frame_field_demux_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire cfd_pkg::in_item_t         in_item,
  output logic                           out_valid,
  output cfd_pkg::out_item_t             out_item,
  input  wire logic                      cfg_we,
  input  wire logic [4:0]                cfg_wdata
);
  import cfd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FREAD = 6'b000010,
    ST_FCMP  = 6'b000100,
    ST_MREAD = 6'b001000,
    ST_MCHK  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [FCNT_W-1:0]   active_r;
  logic [FCNT_W-1:0]   f_r, f_nxt;
  logic [FSLOT_W-1:0]  fsel_r, fsel_nxt;
  logic [MCNT_W-1:0]   j_r, j_nxt;
  logic [MCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [28:0]         id_r;
  logic                ext_r;
  logic [3:0]          dlc_r;
  logic [63:0]         payload_r;
  logic                pend_v_r, pend_v_nxt;
  out_item_t           pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                accept;
  tbl_wr_t             wr;
  filter_entry_t       filt_rdata;
  map_entry_t          map_rdata;
  logic                ex_hit;
  out_item_t           ex_item;
  logic                fmatch;
  logic [FCNT_W-1:0]   f_inc;
  logic [MCNT_W-1:0]   j_inc;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Load commands write straight into the tables
  always_comb begin
    wr.filt_we     = accept && (in_item.command == CMD_FILTER);
    wr.map_we      = accept && (in_item.command == CMD_MAP);
    wr.fslot       = in_item.frame_slot;
    wr.maddr       = {in_item.frame_slot, in_item.map_slot};
    wr.filt.ident  = in_item.can_id;
    wr.filt.ext    = in_item.extended;
    wr.filt.count  = (in_item.length > MCNT_W'(MAPS_PER_FILTER)) ?
                     MCNT_W'(MAPS_PER_FILTER) : in_item.length[MCNT_W-1:0];
    wr.map.kind    = in_item.data_kind;
    wr.map.offset  = in_item.start_byte;
    wr.map.bit_sel = in_item.bit_index;
    wr.map.area    = in_item.target_area;
    wr.map.index   = in_item.target_index;
  end

  cfd_table_store u_store (
    .clk        (clk),
    .wr         (wr),
    .filt_raddr (f_r[FSLOT_W-1:0]),
    .filt_rdata (filt_rdata),
    .map_raddr  ({fsel_r, j_r[MSLOT_W-1:0]}),
    .map_rdata  (map_rdata)
  );

  cfd_extract u_extract (
    .map     (map_rdata),
    .payload (payload_r),
    .dlc     (dlc_r),
    .hit     (ex_hit),
    .item    (ex_item)
  );

  assign fmatch = (filt_rdata.ident == id_r) && (filt_rdata.ext == ext_r);
  assign f_inc  = f_r + FCNT_W'(1);
  assign j_inc  = j_r + MCNT_W'(1);

  // Run sequencer: filter search, then mapping walk with one-result lookahead
  always_comb begin
    state_nxt     = state_r;
    f_nxt         = f_r;
    fsel_nxt      = fsel_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      ST_IDLE: begin
        f_nxt = '0;
        if (accept && (in_item.command == CMD_RECV) && (active_r != '0)) begin
          state_nxt = ST_FREAD;
        end
      end
      ST_FREAD: begin
        state_nxt = ST_FCMP;
      end
      ST_FCMP: begin
        if (fmatch) begin
          fsel_nxt  = f_r[FSLOT_W-1:0];
          cnt_nxt   = filt_rdata.count;
          j_nxt     = '0;
          state_nxt = (filt_rdata.count == '0) ? ST_IDLE : ST_MREAD;
        end else begin
          f_nxt     = f_inc;
          state_nxt = (f_inc == active_r) ? ST_IDLE : ST_FREAD;
        end
      end
      ST_MREAD: begin
        state_nxt = ST_MCHK;
      end
      ST_MCHK: begin
        if (ex_hit) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = pend_r;
          end
          pend_nxt   = ex_item;
          pend_v_nxt = 1'b1;
        end
        j_nxt     = j_inc;
        state_nxt = (j_inc == cnt_r) ? ST_DONE : ST_MREAD;
      end
      ST_DONE: begin
        if (pend_v_r) begin
          out_valid_nxt     = 1'b1;
          out_item_nxt      = pend_r;
          out_item_nxt.last = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt  = ST_IDLE;
        pend_v_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      f_r         <= '0;
      j_r         <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      f_r         <= f_nxt;
      j_r         <= j_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_we) begin
        active_r <= (cfg_wdata > FCNT_W'(FILTER_SLOTS)) ?
                    FCNT_W'(FILTER_SLOTS) : cfg_wdata[FCNT_W-1:0];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fsel_r     <= fsel_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
    if (accept) begin
      id_r      <= in_item.can_id;
      ext_r     <= in_item.extended;
      dlc_r     <= (in_item.length > 5'd8) ? 4'd8 : in_item.length[3:0];
      payload_r <= in_item.payload;
    end
  end

  // A held result only exists inside a run
  a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> (state_r != ST_IDLE))
    else $error("pending result outside a run");

  // Closing a run with a held result emits it marked last
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && pend_v_r) |=> (out_valid_r && out_item_r.last))
    else $error("final result not marked last");

  // An unmarked result only follows a mapping check
  a_mid_from_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.last) |-> ($past(state_r) == ST_MCHK))
    else $error("unmarked result outside the mapping walk");

  // Mapping walk stays inside the filter's mapping count
  a_j_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MCHK) |-> (j_r < cnt_r))
    else $error("mapping index past count");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for can_rx_frame_field_demux_core: loads filter and mapping tables,
// sends frames through the start/busy port and checks each result strobe against
// an in-bench predictor. Depends only on cfd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import cfd_pkg::*;

  localparam logic [1:0] CMD_NONE  = 2'd3;  // unused command code
  localparam int         HUSH_LIM  = 2000;  // cycles with no accepted item and no result before giving up
  localparam int         SETTLE    = 100;   // covers one full filter/mapping walk
  localparam int         FILL_MAPS = 4;     // mapping slots per filter written by the fill

  // Shadow copy of one mapping entry
  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] ofs;
    logic [2:0] bsel;
    logic [3:0] area;
    logic [9:0] idx;
  } map_rec_t;

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    in_item   = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we    = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  can_rx_frame_field_demux_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state
  logic [28:0] flt_id  [FILTER_SLOTS];
  logic        flt_ext [FILTER_SLOTS];
  logic [4:0]  flt_cnt [FILTER_SLOTS];
  map_rec_t    map_tab [FILTER_SLOTS * MAPS_PER_FILTER];
  logic [4:0]  active_cfg = '0;
  out_item_t   pending_fields[$];

  int  n_fail    = 0;
  int  n_checked = 0;
  int  n_frames  = 0;
  int  n_loads   = 0;
  int  n_cfg     = 0;
  bit  no_gaps   = 1'b0;
  int  hush      = 0;
  out_item_t want;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expected results for one accepted item; also tracks table loads
  task automatic extract_fields(input in_item_t it);
    int        nf, dlc, hit, f, j, n, w;
    map_rec_t  m;
    logic [63:0] v;
    out_item_t r, prev;
    case (it.command)
      CMD_FILTER: begin
        flt_id[it.frame_slot]  = it.can_id;
        flt_ext[it.frame_slot] = it.extended;
        flt_cnt[it.frame_slot] = (it.length > 5'd16) ? 5'd16 : it.length;
      end
      CMD_MAP: begin
        map_tab[{it.frame_slot, it.map_slot}] =
          '{it.data_kind, it.start_byte, it.bit_index, it.target_area, it.target_index};
      end
      CMD_RECV: begin
        nf  = (active_cfg > 5'd16) ? 16 : int'(active_cfg);
        dlc = (it.length > 5'd8) ? 8 : int'(it.length);
        hit = -1;
        for (f = 0; f < nf; f++)
          if (hit < 0 && flt_id[f] == it.can_id && flt_ext[f] == it.extended) hit = f;
        if (hit >= 0) begin
          n = 0;
          for (j = 0; j < int'(flt_cnt[hit]) && n < 16; j++) begin
            m = map_tab[hit * MAPS_PER_FILTER + j];
            case (m.kind)
              KIND_BIT, KIND_BYTE: w = 1;
              KIND_WORD:           w = 2;
              KIND_DWORD:          w = 4;
              KIND_LWORD:          w = 8;
              default:             w = 0;
            endcase
            if (w != 0 && int'(m.ofs) + w <= dlc) begin
              v = it.payload >> (int'(m.ofs) * 8);
              if (w < 8) v = v & ((64'd1 << (w * 8)) - 64'd1);
              if (m.kind == KIND_BIT) v = (v >> m.bsel) & 64'd1;
              r.area    = m.area;
              r.index   = m.idx;
              r.bit_res = (m.kind == KIND_BIT) ? m.bsel : 3'd0;
              r.kind    = m.kind;
              r.value   = v;
              r.last    = 1'b0;
              // hold one back so the final one can be marked
              if (n > 0) pending_fields.push_back(prev);
              prev = r;
              n++;
            end
          end
          if (n > 0) begin
            prev.last = 1'b1;
            pending_fields.push_back(prev);
          end
        end
      end
      default: ;
    endcase
  endtask

  // Send one item; returns at the edge it is accepted, start left high
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    extract_fields(it);
    if (it.command == CMD_RECV) n_frames++;
    else if (it.command != CMD_NONE) n_loads++;
    if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
  endtask

  // Drop start, wait for every expected result, then let the walk finish
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_active_filters(input logic [4:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    active_cfg = v;
    cfg_we    <= 1'b0;
    n_cfg++;
  endtask

  function automatic in_item_t rand_item(input logic [1:0] cmd);
    in_item_t it;
    it              = '0;
    it.command      = cmd;
    it.frame_slot   = 4'($urandom);
    it.map_slot     = 4'($urandom);
    it.can_id       = 29'($urandom);
    it.extended     = 1'($urandom);
    it.length       = 5'($urandom);
    it.payload      = {$urandom, $urandom};
    it.data_kind    = 3'($urandom);
    it.start_byte   = 3'($urandom);
    it.bit_index    = 3'($urandom);
    it.target_area  = 4'($urandom);
    it.target_index = 10'($urandom);
    return it;
  endfunction

  // Write every filter and its first mappings; filter counts never reach past them
  task automatic test_table_fill();
    in_item_t it;
    int f, j;
    for (f = 0; f < FILTER_SLOTS; f++) begin
      it = rand_item(CMD_FILTER);
      it.frame_slot = 4'(f);
      it.length = 5'($urandom_range(0, FILL_MAPS));
      send_item(it);
    end
    for (f = 0; f < FILTER_SLOTS; f++)
      for (j = 0; j < FILL_MAPS; j++) begin
        it = rand_item(CMD_MAP);
        it.frame_slot = 4'(f);
        it.map_slot   = 4'(j);
        if ($urandom_range(0, 9) != 0) it.data_kind = 3'($urandom_range(0, 4));
        send_item(it);
      end
  endtask

  // Field extremes, every kind, skips, long frame, first-match and unused command
  task automatic test_directed_extraction();
    in_item_t it;
    int j;
    wait_idle();
    set_active_filters(5'd16);
    // filter 0 with six mappings, filter 1 at max id with saturated count
    it = rand_item(CMD_FILTER);
    it.frame_slot = 4'd0; it.can_id = '0; it.extended = 1'b0; it.length = 5'd6;
    send_item(it);
    it = rand_item(CMD_FILTER);
    it.frame_slot = 4'd1; it.can_id = '1; it.extended = 1'b1; it.length = 5'd31;
    send_item(it);
    // rest of filter 1's mappings, so the saturated count reads written entries only
    for (j = FILL_MAPS; j < MAPS_PER_FILTER; j++) begin
      it = rand_item(CMD_MAP);
      it.frame_slot = 4'd1; it.map_slot = 4'(j);
      if ($urandom_range(0, 9) != 0) it.data_kind = 3'($urandom_range(0, 4));
      send_item(it);
    end
    // duplicate id in a later slot must never win
    it = rand_item(CMD_FILTER);
    it.frame_slot = 4'd2; it.can_id = '0; it.extended = 1'b0; it.length = 5'd1;
    send_item(it);
    // mappings of filter 0: bit, lword, unknown kind, byte, word, dword
    it = rand_item(CMD_MAP);
    it.frame_slot = 4'd0; it.map_slot = 4'd0; it.data_kind = KIND_BIT;
    it.start_byte = 3'd7; it.bit_index = 3'd7; it.target_area = '1; it.target_index = '1;
    send_item(it);
    it = rand_item(CMD_MAP);
    it.frame_slot = 4'd0; it.map_slot = 4'd1; it.data_kind = KIND_LWORD;
    it.start_byte = 3'd0; it.bit_index = 3'd0; it.target_area = '0; it.target_index = '0;
    send_item(it);
    it = rand_item(CMD_MAP);
    it.frame_slot = 4'd0; it.map_slot = 4'd2; it.data_kind = 3'd5; it.start_byte = 3'd0;
    send_item(it);
    it = rand_item(CMD_MAP);
    it.frame_slot = 4'd0; it.map_slot = 4'd3; it.data_kind = KIND_BYTE; it.start_byte = 3'd3;
    send_item(it);
    it = rand_item(CMD_MAP);
    it.frame_slot = 4'd0; it.map_slot = 4'd4; it.data_kind = KIND_WORD; it.start_byte = 3'd6;
    send_item(it);
    it = rand_item(CMD_MAP);
    it.frame_slot = 4'd0; it.map_slot = 4'd5; it.data_kind = KIND_DWORD; it.start_byte = 3'd4;
    send_item(it);
    // frames on filter 0: all ones, pattern, long length, short, empty
    it = rand_item(CMD_RECV);
    it.can_id = '0; it.extended = 1'b0; it.length = 5'd8; it.payload = '1;
    send_item(it);
    it.payload = 64'h0123_4567_89AB_CDEF;
    send_item(it);
    it.length = 5'd31; it.payload = 64'h8000_0000_0000_0000;
    send_item(it);
    it.length = 5'd6; it.payload = '1;
    send_item(it);
    it.length = 5'd0;
    send_item(it);
    // extended flag mismatch on the same id
    it.extended = 1'b1; it.length = 5'd8;
    send_item(it);
    // filter 1: sixteen random mappings
    it = rand_item(CMD_RECV);
    it.can_id = '1; it.extended = 1'b1; it.length = 5'd8;
    send_item(it);
    send_item(rand_item(CMD_NONE));
  endtask

  // With no filters active nothing may match
  task automatic test_no_active_filters();
    in_item_t it;
    int k;
    wait_idle();
    set_active_filters(5'd0);
    for (k = 0; k < 3; k++) begin
      it = rand_item(CMD_RECV);
      it.can_id = flt_id[k]; it.extended = flt_ext[k]; it.length = 5'd8;
      send_item(it);
    end
  endtask

  // Mostly matching frames with random loads mixed in, under one filter setting
  task automatic test_random_traffic(input int n_items, input logic [4:0] cfg);
    in_item_t it;
    int done, pick, nf, s;
    wait_idle();
    set_active_filters(cfg);
    nf = (cfg > 5'd16) ? 16 : int'(cfg);
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        it = rand_item(CMD_NONE);
      end else if (pick < 18) begin
        it = rand_item(CMD_FILTER);
        it.length = 5'($urandom_range(0, FILL_MAPS));
        if ($urandom_range(0, 3) == 0) begin
          s = $urandom_range(0, FILTER_SLOTS - 1);
          it.can_id = flt_id[s]; it.extended = flt_ext[s];
        end
      end else if (pick < 38) begin
        it = rand_item(CMD_MAP);
        if ($urandom_range(0, 6) != 0) it.data_kind = 3'($urandom_range(0, 4));
      end else begin
        it = rand_item(CMD_RECV);
        if (nf > 0 && $urandom_range(0, 99) < 85) begin
          s = $urandom_range(0, nf - 1);
          it.can_id = flt_id[s]; it.extended = flt_ext[s];
        end
        if ($urandom_range(0, 9) < 7) it.length = 5'd8;
      end
      send_item(it);
      if (it.command != CMD_NONE) done++;
    end
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
      n_fail++;
    end
  endfunction

  // Result checker: every strobe is compared with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected result: area %0h index %0h value %0h",
               out_item.area, out_item.index, out_item.value);
        n_fail++;
      end else begin
        want = pending_fields.pop_front();
        check_field("area",    64'(want.area),    64'(out_item.area));
        check_field("index",   64'(want.index),   64'(out_item.index));
        check_field("bit_res", 64'(want.bit_res), 64'(out_item.bit_res));
        check_field("kind",    64'(want.kind),    64'(out_item.kind));
        check_field("value",   want.value,        out_item.value);
        check_field("last",    64'(want.last),    64'(out_item.last));
        n_checked++;
      end
    end
  end

  // Watchdog: no item taken and no result for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) hush <= 0;
    else hush <= hush + 1;
    if (hush >= HUSH_LIM) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_table_fill();
    test_directed_extraction();
    test_no_active_filters();
    test_random_traffic(60, 5'd16);
    test_random_traffic(50, 5'd31);
    test_random_traffic(45, 5'($urandom_range(1, 15)));
    test_random_traffic(35, 5'd1);
    wait_idle();
    $display("covered %0d frames and %0d table loads under %0d filter settings",
             n_frames, n_loads, n_cfg);
    $display("%0d results checked, %0d mismatches", n_checked, n_fail);
    if (n_fail == 0 && pending_fields.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
